// ----- rtl/core/toggle_membership_queue_top_macros.svh -----
// Assertion macros shared by the toggle membership queue RTL.
`ifndef TOGGLE_MEMBERSHIP_QUEUE_TOP_MACROS_SVH
`define TOGGLE_MEMBERSHIP_QUEUE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define TMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define TMQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TMQ_ASSERT(lbl, prop, msg)
`define TMQ_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- rtl/core/tmq_pkg.sv -----
// Package with types and constants of the toggle membership queue.
package tmq_pkg;

  localparam int DEPTH   = 32;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int MAC_W   = 48;
  localparam int POS_W   = 5;
  localparam int LED_W   = 2;
  localparam int QLEN_W  = 6;

  localparam logic CMD_TOGGLE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic [LED_W-1:0] LED_OFF   = 2'd0;
  localparam logic [LED_W-1:0] LED_GREEN = 2'd1;
  localparam logic [LED_W-1:0] LED_RED   = 2'd2;

  typedef struct packed {
    logic             cmd;
    logic [MAC_W-1:0] station_mac;
  } tmq_in_t;

  typedef struct packed {
    logic              was_added;
    logic              was_removed;
    logic              full_drop;
    logic              found;
    logic [POS_W-1:0]  position;
    logic [LED_W-1:0]  led_state;
    logic [QLEN_W-1:0] queue_length;
  } tmq_out_t;

endpackage

// ----- rtl/core/toggle_membership_queue_top.sv -----
// Toggle membership queue: ordered station address queue with search and delete.
//
// Keeps up to DEPTH (32) 48-bit station addresses in arrival order in one
// single-port-style memory (one write and one registered read per cycle).
// A toggle transaction removes the address if queued, closing the gap, or
// appends it at the tail; an append into a full queue is dropped and flagged.
// A query transaction reports presence, zero-based position and indicator
// state (off, green when first, red when waiting) and never changes the queue.
// One item is in work at a time. The search reads one entry and compares it
// on the next cycle; a removal then moves each later entry with a read and a
// write. Search and moves step through the entries one at a time on the one
// memory read port. The result sits in an output register, so the next
// transaction is accepted while the previous result still waits for
// out_ready; that next item then holds in its finish step until the register
// is taken. The queue is empty after reset and needs no clearing pass: only
// entries below the fill count are read.
`include "toggle_membership_queue_top_macros.svh"

module toggle_membership_queue_top
  import tmq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  tmq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output tmq_out_t out_data
);

  // Sequencer codes.
  localparam logic [2:0] S_IDLE = 3'd0;  // wait for a transaction
  localparam logic [2:0] S_RD   = 3'd1;  // issue search read or finish miss
  localparam logic [2:0] S_CMP  = 3'd2;  // compare read data with address
  localparam logic [2:0] S_SRD  = 3'd3;  // read next entry to move up
  localparam logic [2:0] S_SWR  = 3'd4;  // write moved entry one place up
  localparam logic [2:0] S_FIN  = 3'd5;  // hand result to output register

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  tmq_in_t          req_r, req_nxt;
  tmq_out_t         res_r, res_nxt;
  tmq_out_t         out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Queue storage; entries at and above the fill count are never read.
  logic [MAC_W-1:0] mem [DEPTH];
  logic [MAC_W-1:0] rd_data_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [MAC_W-1:0] mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;

  logic [CNT_W:0]   idx_inc;
  logic             out_free;

  // Result summaries for the checks below.
  logic [3:0]       out_outcome;
  logic             out_led_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;
  assign idx_inc   = {1'b0, idx_r} + 1'b1;

  assign out_outcome = {out_r.was_added, out_r.was_removed, out_r.full_drop, out_r.found};
  assign out_led_ok  = ((out_r.led_state == LED_GREEN) == (out_r.position == '0));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r[IDX_W-1:0];
    mem_wdata     = req_r.station_mac;
    mem_re        = 1'b0;
    mem_raddr     = idx_r[IDX_W-1:0];

    // Retire the held result once taken.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          res_nxt   = '0;
          idx_nxt   = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (idx_r == count_r) begin
          // Searched every entry without a hit.
          if (req_r.cmd == CMD_TOGGLE) begin
            if (count_r == CNT_W'(DEPTH)) begin
              res_nxt.full_drop = 1'b1;
            end else begin
              // Append at the tail.
              mem_we            = 1'b1;
              mem_waddr         = count_r[IDX_W-1:0];
              count_nxt         = count_r + 1'b1;
              res_nxt.was_added = 1'b1;
            end
          end
          state_nxt = S_FIN;
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (rd_data_r == req_r.station_mac) begin
          if (req_r.cmd == CMD_QUERY) begin
            res_nxt.found     = 1'b1;
            res_nxt.position  = POS_W'(idx_r);
            res_nxt.led_state = (idx_r == '0) ? LED_GREEN : LED_RED;
            state_nxt         = S_FIN;
          end else begin
            res_nxt.was_removed = 1'b1;
            state_nxt           = S_SRD;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_SRD: begin
        if (idx_inc >= {1'b0, count_r}) begin
          // Gap reached the tail: drop the last entry.
          count_nxt = count_r - 1'b1;
          state_nxt = S_FIN;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_inc[IDX_W-1:0];
          state_nxt = S_SWR;
        end
      end
      S_SWR: begin
        // Move the later entry up one place; the read was issued in the cycle before.
        mem_we    = 1'b1;
        mem_wdata = rd_data_r;
        idx_nxt   = idx_inc[CNT_W-1:0];
        state_nxt = S_SRD;
      end
      S_FIN: begin
        if (out_free) begin
          out_nxt              = res_r;
          out_nxt.queue_length = QLEN_W'(count_r);
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    req_r <= req_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  `TMQ_ASSERT(a_count_bound, count_r <= CNT_W'(DEPTH), "fill count above queue depth")
  `TMQ_ASSERT(a_one_outcome, out_valid_r |-> $onehot0(out_outcome), "result has two outcomes")
  `TMQ_ASSERT(a_led_pos, (out_valid_r && out_r.found) |-> out_led_ok, "indicator vs position")
  `TMQ_ASSERT(a_accept_holds_count, (in_valid && in_ready) |=> $stable(count_r), "count moved")
  `TMQ_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_valid_r), "reset missed")

endmodule
